// File: rtl/core/bbp_pkg.sv
// Shared types, constants and the control program of the bouncing ball step block.
// Used by bbp_datapath and bouncing_ball_physics_step; depends on nothing else.
`default_nettype none

package bbp_pkg;

  // Fixed-point widths.
  localparam int unsigned QW    = 24;  // Q12.12 state and field values
  localparam int unsigned FW    = 18;  // Q1.16 multiplier factors
  localparam int unsigned SW    = 28;  // headroom for sums before saturation
  localparam int unsigned AW    = 26;  // floored product and wall coordinates
  localparam int unsigned PW    = QW + FW;
  localparam int unsigned PcW   = 4;
  localparam int unsigned CfgIw = 3;

  // Item function codes.
  localparam logic FuncTick = 1'b0;
  localparam logic FuncLoad = 1'b1;

  localparam logic signed [QW-1:0] QMax       = 24'sh7FFFFF;
  localparam logic signed [QW-1:0] QMin       = 24'sh800000;
  localparam logic signed [QW-1:0] HalfSpeed  = 24'sd2048;
  localparam logic signed [QW-1:0] PosXReset  = 24'sd819200;
  localparam logic signed [QW-1:0] PosYReset  = 24'sd1638400;

  // Configuration register defaults.
  localparam logic [17:0] DampingReset  = 18'd65529;
  localparam logic [23:0] GravityReset  = 24'd819;
  localparam logic [17:0] RestitReset   = 18'h33333;  // -52429 in 18 bits
  localparam logic [16:0] FrictionReset = 17'd6554;
  localparam logic [7:0]  RadiusReset   = 8'd50;
  localparam logic [11:0] WidthReset    = 12'd960;
  localparam logic [11:0] HeightReset   = 12'd600;

  // Program addresses where an item starts.
  localparam logic [PcW-1:0] PcTick = 4'd0;
  localparam logic [PcW-1:0] PcDone = 4'd15;

  typedef enum logic [CfgIw-1:0] {
    CFG_DAMPING  = 3'd0,
    CFG_GRAVITY  = 3'd1,
    CFG_RESTIT   = 3'd2,
    CFG_FRICTION = 3'd3,
    CFG_RADIUS   = 3'd4,
    CFG_WIDTH    = 3'd5,
    CFG_HEIGHT   = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_GRAV  = 4'd1,
    OP_MOVE  = 4'd2,
    OP_FLOOR = 4'd3,
    OP_ZERO  = 4'd4,
    OP_TOP   = 4'd5,
    OP_RIGHT = 4'd6,
    OP_LEFT  = 4'd7,
    OP_AMT   = 4'd8,
    OP_FRIC  = 4'd9,
    OP_DAMPX = 4'd10,
    OP_DAMPY = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE       = 3'd0,
    COND_FLOOR_MISS = 3'd1,
    COND_TOP_MISS   = 3'd2,
    COND_RIGHT_MISS = 3'd3,
    COND_LEFT_MISS  = 3'd4
  } cond_e;

  // One control word of the program.
  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           last;
  } ctl_t;

  // Datapath command from the sequencer.
  typedef struct packed {
    op_e  op;
    logic load;
    logic clear_gnd;
  } dp_cmd_t;

  // Wall contact flags from the datapath, on the current state.
  typedef struct packed {
    logic floor_hit;
    logic top_hit;
    logic right_hit;
    logic left_hit;
  } dp_stat_t;

  function automatic ctl_t mk(op_e op, cond_e cond, logic [PcW-1:0] target, logic last);
    ctl_t c;
    c.op     = op;
    c.cond   = cond;
    c.target = target;
    c.last   = last;
    return c;
  endfunction

  // The tick program. A test step jumps past its action step when the wall is missed.
  function automatic ctl_t bbp_rom(logic [PcW-1:0] pc);
    ctl_t c;
    case (pc)
      4'd0:    c = mk(OP_GRAV,  COND_NONE,       4'd0,  1'b0);
      4'd1:    c = mk(OP_MOVE,  COND_NONE,       4'd0,  1'b0);
      4'd2:    c = mk(OP_NOP,   COND_FLOOR_MISS, 4'd5,  1'b0);
      4'd3:    c = mk(OP_FLOOR, COND_NONE,       4'd0,  1'b0);
      4'd4:    c = mk(OP_ZERO,  COND_NONE,       4'd0,  1'b0);
      4'd5:    c = mk(OP_NOP,   COND_TOP_MISS,   4'd7,  1'b0);
      4'd6:    c = mk(OP_TOP,   COND_NONE,       4'd0,  1'b0);
      4'd7:    c = mk(OP_NOP,   COND_RIGHT_MISS, 4'd9,  1'b0);
      4'd8:    c = mk(OP_RIGHT, COND_NONE,       4'd0,  1'b0);
      4'd9:    c = mk(OP_NOP,   COND_LEFT_MISS,  4'd11, 1'b0);
      4'd10:   c = mk(OP_LEFT,  COND_NONE,       4'd0,  1'b0);
      4'd11:   c = mk(OP_AMT,   COND_NONE,       4'd0,  1'b0);
      4'd12:   c = mk(OP_FRIC,  COND_NONE,       4'd0,  1'b0);
      4'd13:   c = mk(OP_DAMPX, COND_NONE,       4'd0,  1'b0);
      4'd14:   c = mk(OP_DAMPY, COND_NONE,       4'd0,  1'b0);
      default: c = mk(OP_NOP,   COND_NONE,       4'd0,  1'b1);
    endcase
    return c;
  endfunction

  // Saturate a widened sum to the Q12.12 range.
  function automatic logic signed [QW-1:0] sat24(logic signed [SW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > $signed({{(SW-QW){QMax[QW-1]}}, QMax})) begin
      r = QMax;
    end else if (v < $signed({{(SW-QW){QMin[QW-1]}}, QMin})) begin
      r = QMin;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bouncing_ball_physics_step.sv
// Top level of the bouncing ball step block: config registers, handshakes and
// the microcoded sequencer. Depends on bbp_pkg and bbp_datapath.
//
//   channel | direction | handshake              | payload
//   cfg     | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//   in      | in        | in_valid_i, in_stall_o | func_i, load_x_i .. load_vy_i
//   out     | out       | out_valid_o, out_stall_i | pos_x_o .. vel_y_o, on_ground_o
//
// A tick item runs the program from step 0, one step after the other, with a wall
// that is not touched skipping its action steps. A load item writes the state on
// acceptance and goes straight to the final step, which gives its result.
// Reset restores the register defaults and the ball state at once; no sweep.
// A stalled output holds the sequencer at its final step; the result register
// lets the next item be accepted while the previous result waits.
`default_nettype none

module bouncing_ball_physics_step (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [23:0]        cfg_wdata_i,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire                     func_i,
  input  wire logic signed [23:0] load_x_i,
  input  wire logic signed [23:0] load_y_i,
  input  wire logic signed [23:0] load_vx_i,
  input  wire logic signed [23:0] load_vy_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic signed [23:0]      pos_x_o,
  output logic signed [23:0]      pos_y_o,
  output logic signed [23:0]      vel_x_o,
  output logic signed [23:0]      vel_y_o,
  output logic                    on_ground_o
);

  logic [17:0] damping_q;
  logic [23:0] gravity_q;
  logic [17:0] restit_q;
  logic [16:0] friction_q;
  logic [7:0]  radius_q;
  logic [11:0] width_q;
  logic [11:0] height_q;

  logic                   busy_q, busy_d;
  logic [bbp_pkg::PcW-1:0] pc_q, pc_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [23:0]     out_px_q, out_py_q, out_vx_q, out_vy_q;
  logic                   out_gnd_q;

  bbp_pkg::ctl_t     ctl;
  bbp_pkg::dp_cmd_t  cmd;
  bbp_pkg::dp_stat_t stat;
  logic              accept, finish, out_free, jump, is_load;
  logic signed [23:0] st_px, st_py, st_vx, st_vy;
  logic              st_gnd;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q  <= bbp_pkg::DampingReset;
      gravity_q  <= bbp_pkg::GravityReset;
      restit_q   <= bbp_pkg::RestitReset;
      friction_q <= bbp_pkg::FrictionReset;
      radius_q   <= bbp_pkg::RadiusReset;
      width_q    <= bbp_pkg::WidthReset;
      height_q   <= bbp_pkg::HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbp_pkg::CFG_DAMPING:  damping_q  <= cfg_wdata_i[17:0];
        bbp_pkg::CFG_GRAVITY:  gravity_q  <= cfg_wdata_i;
        bbp_pkg::CFG_RESTIT:   restit_q   <= cfg_wdata_i[17:0];
        bbp_pkg::CFG_FRICTION: friction_q <= cfg_wdata_i[16:0];
        bbp_pkg::CFG_RADIUS:   radius_q   <= cfg_wdata_i[7:0];
        bbp_pkg::CFG_WIDTH:    width_q    <= cfg_wdata_i[11:0];
        bbp_pkg::CFG_HEIGHT:   height_q   <= cfg_wdata_i[11:0];
        default: begin
        end
      endcase
    end
  end

  // Control word for the current step and the jump decision.
  assign ctl = bbp_pkg::bbp_rom(pc_q);

  always_comb begin
    case (ctl.cond)
      bbp_pkg::COND_FLOOR_MISS: jump = !stat.floor_hit;
      bbp_pkg::COND_TOP_MISS:   jump = !stat.top_hit;
      bbp_pkg::COND_RIGHT_MISS: jump = !stat.right_hit;
      bbp_pkg::COND_LEFT_MISS:  jump = !stat.left_hit;
      default:                  jump = 1'b0;
    endcase
  end

  assign is_load    = (func_i == bbp_pkg::FuncLoad);
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = busy_q && ctl.last && out_free;

  assign cmd.op        = busy_q ? ctl.op : bbp_pkg::OP_NOP;
  assign cmd.load      = accept && is_load;
  assign cmd.clear_gnd = accept;

  // Sequencer: an accepted item starts the program, the final step waits for room.
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = is_load ? bbp_pkg::PcDone : bbp_pkg::PcTick;
    end else if (busy_q) begin
      if (ctl.last) begin
        if (out_free) begin
          busy_d = 1'b0;
        end
      end else if (jump) begin
        pc_d = ctl.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= bbp_pkg::PcTick;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register holds a copy of the state taken at the final step.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_px_q  <= st_px;
      out_py_q  <= st_py;
      out_vx_q  <= st_vx;
      out_vy_q  <= st_vy;
      out_gnd_q <= st_gnd;
    end
  end

  bbp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .load_x_i   (load_x_i),
    .load_y_i   (load_y_i),
    .load_vx_i  (load_vx_i),
    .load_vy_i  (load_vy_i),
    .damping_i  (damping_q),
    .gravity_i  (gravity_q),
    .restit_i   (restit_q),
    .friction_i (friction_q),
    .radius_i   (radius_q),
    .width_i    (width_q),
    .height_i   (height_q),
    .stat_o     (stat),
    .pos_x_o    (st_px),
    .pos_y_o    (st_py),
    .vel_x_o    (st_vx),
    .vel_y_o    (st_vy),
    .gnd_o      (st_gnd)
  );

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_px_q;
  assign pos_y_o     = out_py_q;
  assign vel_x_o     = out_vx_q;
  assign vel_y_o     = out_vy_q;
  assign on_ground_o = out_gnd_q;

  // An accepted item always occupies the sequencer in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("sequencer not busy after an accepted item");

  // A new result appears only when the sequencer was running.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("result raised without a running item");

  // The sequencer leaves busy only through the final step.
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !ctl.last) |=> busy_q)
    else $error("sequencer dropped busy before its final step");

  // A load goes straight to the final step with no ground contact.
  a_load_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load) |=> (pc_q == bbp_pkg::PcDone) && !st_gnd)
    else $error("load item did not go to the final step");

endmodule

`default_nettype wire

// File: rtl/core/bbp_datapath.sv
// Ball state registers with one shared multiplier, adders and wall comparators.
// Executes one operation per cycle as commanded; depends on bbp_pkg.
`default_nettype none

module bbp_datapath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire bbp_pkg::dp_cmd_t         cmd_i,
  input  wire logic signed [23:0]       load_x_i,
  input  wire logic signed [23:0]       load_y_i,
  input  wire logic signed [23:0]       load_vx_i,
  input  wire logic signed [23:0]       load_vy_i,
  input  wire logic [17:0]              damping_i,
  input  wire logic [23:0]              gravity_i,
  input  wire logic [17:0]              restit_i,
  input  wire logic [16:0]              friction_i,
  input  wire logic [7:0]               radius_i,
  input  wire logic [11:0]              width_i,
  input  wire logic [11:0]              height_i,
  output bbp_pkg::dp_stat_t             stat_o,
  output logic signed [23:0]            pos_x_o,
  output logic signed [23:0]            pos_y_o,
  output logic signed [23:0]            vel_x_o,
  output logic signed [23:0]            vel_y_o,
  output logic                          gnd_o
);

  logic signed [23:0] px_q, px_d, py_q, py_d, vx_q, vx_d, vy_q, vy_d;
  logic signed [25:0] amt_q, amt_d;
  logic               gnd_q, gnd_d;

  logic signed [25:0] rad, wid, hgt;
  logic signed [25:0] px_w, py_w;
  logic signed [23:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [41:0] prod;
  logic signed [25:0] prod_fl;
  logic signed [23:0] prod_sat;
  logic signed [27:0] vx_w, vy_w, amt_w;
  logic               grounded;

  // Wall coordinates in Q12.12, widened so comparisons stay exact.
  assign rad  = $signed({6'd0, radius_i, 12'd0});
  assign wid  = $signed({2'd0, width_i, 12'd0});
  assign hgt  = $signed({2'd0, height_i, 12'd0});
  assign px_w = $signed({{2{px_q[23]}}, px_q});
  assign py_w = $signed({{2{py_q[23]}}, py_q});

  assign stat_o.floor_hit = (py_w + rad) > hgt;
  assign stat_o.top_hit   = (py_w - rad) < 26'sd0;
  assign stat_o.right_hit = (px_w + rad) > wid;
  assign stat_o.left_hit  = (px_w - rad) < 26'sd0;
  assign grounded         = (py_w + rad) >= hgt;

  // Shared multiplier: velocity or gravity times a Q1.16 factor, floored.
  always_comb begin
    case (cmd_i.op)
      bbp_pkg::OP_FLOOR, bbp_pkg::OP_TOP, bbp_pkg::OP_DAMPY: mul_a = vy_q;
      bbp_pkg::OP_AMT:                                       mul_a = $signed(gravity_i);
      default:                                               mul_a = vx_q;
    endcase
    case (cmd_i.op)
      bbp_pkg::OP_DAMPX, bbp_pkg::OP_DAMPY: mul_b = $signed(damping_i);
      bbp_pkg::OP_AMT:                      mul_b = $signed({1'b0, friction_i});
      default:                              mul_b = $signed(restit_i);
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_fl  = prod[41:16];
  assign prod_sat = bbp_pkg::sat24($signed({{2{prod_fl[25]}}, prod_fl}));

  assign vx_w  = $signed({{4{vx_q[23]}}, vx_q});
  assign vy_w  = $signed({{4{vy_q[23]}}, vy_q});
  assign amt_w = $signed({{2{amt_q[25]}}, amt_q});

  // Operation decode.
  always_comb begin
    px_d  = px_q;
    py_d  = py_q;
    vx_d  = vx_q;
    vy_d  = vy_q;
    amt_d = amt_q;
    gnd_d = gnd_q;
    if (cmd_i.load) begin
      px_d  = load_x_i;
      py_d  = load_y_i;
      vx_d  = load_vx_i;
      vy_d  = load_vy_i;
      gnd_d = 1'b0;
    end else begin
      if (cmd_i.clear_gnd) begin
        gnd_d = 1'b0;
      end
      case (cmd_i.op)
        bbp_pkg::OP_GRAV: begin
          vy_d = bbp_pkg::sat24(vy_w + $signed({{4{gravity_i[23]}}, gravity_i}));
        end
        bbp_pkg::OP_MOVE: begin
          px_d = bbp_pkg::sat24($signed({{4{px_q[23]}}, px_q})
                                + $signed({vx_q[23], vx_q, 3'b000}));
          py_d = bbp_pkg::sat24($signed({{4{py_q[23]}}, py_q})
                                + $signed({vy_q[23], vy_q, 3'b000}));
        end
        bbp_pkg::OP_FLOOR: begin
          py_d = bbp_pkg::sat24($signed({{2{hgt[25]}}, hgt}) - $signed({2'b00, rad}));
          vy_d = prod_sat;
        end
        bbp_pkg::OP_ZERO: begin
          if ((vy_q < bbp_pkg::HalfSpeed) && (vy_q > -bbp_pkg::HalfSpeed)) begin
            vy_d = '0;
          end
        end
        bbp_pkg::OP_TOP: begin
          py_d = bbp_pkg::sat24($signed({2'b00, rad}));
          vy_d = prod_sat;
        end
        bbp_pkg::OP_RIGHT: begin
          px_d = bbp_pkg::sat24($signed({{2{wid[25]}}, wid}) - $signed({2'b00, rad}));
          vx_d = prod_sat;
        end
        bbp_pkg::OP_LEFT: begin
          px_d = bbp_pkg::sat24($signed({2'b00, rad}));
          vx_d = prod_sat;
        end
        bbp_pkg::OP_AMT: begin
          amt_d = prod_fl;
        end
        bbp_pkg::OP_FRIC: begin
          // Friction pushes against the horizontal motion; zero counts as positive.
          if (grounded) begin
            gnd_d = 1'b1;
            if (vx_q[23]) begin
              vx_d = bbp_pkg::sat24(vx_w + amt_w);
            end else begin
              vx_d = bbp_pkg::sat24(vx_w - amt_w);
            end
          end
        end
        bbp_pkg::OP_DAMPX: begin
          vx_d = prod_sat;
        end
        bbp_pkg::OP_DAMPY: begin
          vy_d = prod_sat;
        end
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q  <= bbp_pkg::PosXReset;
      py_q  <= bbp_pkg::PosYReset;
      vx_q  <= '0;
      vy_q  <= '0;
      gnd_q <= 1'b0;
    end else begin
      px_q  <= px_d;
      py_q  <= py_d;
      vx_q  <= vx_d;
      vy_q  <= vy_d;
      gnd_q <= gnd_d;
    end
  end

  // Friction amount is scratch data.
  always_ff @(posedge clk_i) begin
    amt_q <= amt_d;
  end

  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign vel_x_o = vx_q;
  assign vel_y_o = vy_q;
  assign gnd_o   = gnd_q;

endmodule

`default_nettype wire
